// File: rtl/gcbi_pkg.sv
package gcbi_pkg;

  typedef enum logic [2:0] {
    MODE_TICK  = 3'd0,
    MODE_START = 3'd1,
    MODE_STOP  = 3'd2,
    MODE_RESET = 3'd3,
    MODE_LOAD  = 3'd4
  } gcbi_mode_e;

  typedef enum logic [1:0] {
    ERR_OK         = 2'd0,
    ERR_START      = 2'd1,
    ERR_STOP_IDLE  = 2'd2
  } gcbi_err_e;

  localparam logic [1:0] REG_MAIN_TIME   = 2'd0;
  localparam logic [1:0] REG_BYOYOMI     = 2'd1;
  localparam logic [1:0] REG_STONES      = 2'd2;
  localparam logic [1:0] REG_INCREMENT   = 2'd3;

  localparam int unsigned TimeW = 34;

  localparam logic signed [TimeW-1:0] TimeMin = {1'b1, {(TimeW-1){1'b0}}};

endpackage

// File: rtl/game_clock_byoyomi_increment_core.sv
// Game clock with main time, Canadian byoyomi and Fischer increment. Each accepted
// command (tick, start, stop, reset, load) updates the clock state at the accept edge
// and yields exactly one result via the output register; a new command
// is taken every cycle while the result side keeps up. The clock state is a 34-bit
// signed remaining time plus a stone counter; the result derives total, main and
// byoyomi times from it, clamped to 0..2^32-1. Registers sit at byte addresses
// 0 main time, 4 byoyomi period, 8 stones per period, 12 increment, and must only be
// written while no command is in flight; writes do not alter the running clock.
module game_clock_byoyomi_increment_core
  import gcbi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [30:0] main_left_in_ms_i,
  input  logic [15:0] stones_left_in_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] time_left_ms_o,
  output logic [31:0] main_left_ms_o,
  output logic [31:0] byoyomi_left_ms_o,
  output logic [15:0] stones_left_o,
  output logic        ticking_o,
  output logic        timed_out_o,
  output logic [1:0]  error_o
);

  logic [30:0] main_time_q;
  logic [30:0] byo_ms_q;
  logic [15:0] byo_stones_q;
  logic [30:0] incr_q;

  logic signed [TimeW-1:0] time_q, time_d;
  logic [15:0]             stones_q, stones_d;
  logic                    running_q, running_d;
  logic                    overrun_q, overrun_d;

  logic      s1_valid_q;
  gcbi_err_e s1_err_q, err_d;

  logic        out_valid_q;
  logic [31:0] total_q, main_q, byo_left_q;
  logic [15:0] stones_out_q;
  logic        ticking_q, timed_out_q;
  gcbi_err_e   err_out_q;

  logic in_xfer;
  logic s1_adv;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_MAIN_TIME: prdata = {1'b0, main_time_q};
      REG_BYOYOMI:   prdata = {1'b0, byo_ms_q};
      REG_STONES:    prdata = {16'd0, byo_stones_q};
      REG_INCREMENT: prdata = {1'b0, incr_q};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_time_q  <= '0;
      byo_ms_q     <= '0;
      byo_stones_q <= '0;
      incr_q       <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MAIN_TIME: main_time_q  <= pwdata[30:0];
        REG_BYOYOMI:   byo_ms_q     <= pwdata[30:0];
        REG_STONES:    byo_stones_q <= pwdata[15:0];
        REG_INCREMENT: incr_q       <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  assign s1_adv     = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | ~out_valid_q | out_ready_i;
  assign in_xfer    = in_valid_i & in_ready_o;

  logic signed [TimeW-1:0] byo_s;
  logic signed [TimeW-1:0] stop_base;
  logic signed [TimeW-1:0] stop_sum;
  logic [15:0]             stones_dec;
  logic                    reload;

  assign byo_s      = {3'b000, byo_ms_q};
  assign stones_dec = (stones_q == 16'd0) ? 16'd0 : stones_q - 16'd1;
  assign reload     = (time_q < byo_s) && (stones_dec == 16'd0);
  assign stop_base  = reload ? byo_s : time_q;
  assign stop_sum   = stop_base + {3'b000, incr_q};

  always_comb begin
    time_d    = time_q;
    stones_d  = stones_q;
    running_d = running_q;
    overrun_d = overrun_q;
    err_d     = ERR_OK;
    case (gcbi_mode_e'(mode_i))
      MODE_TICK: begin
        if (running_q && time_q != TimeMin) time_d = time_q - 34'sd1;
      end
      MODE_START: begin
        if (running_q || overrun_q) err_d = ERR_START;
        else running_d = 1'b1;
      end
      MODE_STOP: begin
        if (!running_q) begin
          err_d = ERR_STOP_IDLE;
        end else begin
          running_d = 1'b0;
          if (time_q[TimeW-1]) begin
            time_d    = '0;
            overrun_d = 1'b1;
          end else begin
            if (time_q < byo_s) stones_d = reload ? byo_stones_q : stones_dec;
            time_d = (stop_sum[33:32] != 2'b00) ? 34'sh0_FFFF_FFFF : stop_sum;
          end
        end
      end
      MODE_RESET: begin
        running_d = 1'b0;
        overrun_d = 1'b0;
        time_d    = {2'b00, {1'b0, main_time_q} + {1'b0, byo_ms_q}};
        stones_d  = byo_stones_q;
      end
      MODE_LOAD: begin
        running_d = 1'b0;
        time_d    = {2'b00, {1'b0, main_left_in_ms_i} + {1'b0, byo_ms_q}};
        stones_d  = stones_left_in_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q     <= '0;
      stones_q   <= '0;
      running_q  <= 1'b0;
      overrun_q  <= 1'b0;
      s1_valid_q <= 1'b0;
      s1_err_q   <= ERR_OK;
    end else begin
      if (in_xfer) begin
        time_q    <= time_d;
        stones_q  <= stones_d;
        running_q <= running_d;
        overrun_q <= overrun_d;
        s1_err_q  <= err_d;
      end
      if (in_xfer) s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
    end
  end

  logic signed [TimeW:0] main_diff;
  logic [31:0]           total_c, main_c;

  assign main_diff = {time_q[TimeW-1], time_q} - {4'b0000, byo_ms_q};
  assign total_c   = time_q[TimeW-1] ? 32'd0 : time_q[31:0];
  assign main_c    = main_diff[TimeW] ? 32'd0 : main_diff[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      total_q      <= total_c;
      main_q       <= main_c;
      byo_left_q   <= (main_c != 32'd0) ? {1'b0, byo_ms_q} : total_c;
      stones_out_q <= stones_q;
      ticking_q    <= running_q;
      timed_out_q  <= overrun_q;
      err_out_q    <= s1_err_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign time_left_ms_o    = total_q;
  assign main_left_ms_o    = main_q;
  assign byoyomi_left_ms_o = byo_left_q;
  assign stones_left_o     = stones_out_q;
  assign ticking_o         = ticking_q;
  assign timed_out_o       = timed_out_q;
  assign error_o           = err_out_q;

endmodule
